// ----- rtl/frame_header_deframer_top_defines.svh -----
`ifndef FRAME_HEADER_DEFRAMER_TOP_DEFINES_SVH
`define FRAME_HEADER_DEFRAMER_TOP_DEFINES_SVH

// checked outside reset
`define FHD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define FHD_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/fhd_pkg.sv -----
package fhd_pkg;

    localparam logic [31:0] MAGIC_WORD    = 32'h4652_414D;
    localparam logic [31:0] FLAG_KEY      = 32'h0000_0001;
    localparam logic [31:0] FLAG_END      = 32'h0000_0004;
    localparam logic [31:0] FLAG_CFG      = 32'h0000_0008;
    localparam logic [31:0] FLAGS_ALLOWED = FLAG_KEY | FLAG_END | FLAG_CFG;
    localparam logic [23:0] LEN_RESET     = 24'd8388608;

    localparam logic [1:0] KIND_HEADER  = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_DROP    = 2'd2;

    localparam logic [1:0] FMT_BE_LTF = 2'd0;
    localparam logic [1:0] FMT_LE_LTF = 2'd1;
    localparam logic [1:0] FMT_BE_FLT = 2'd2;
    localparam logic [1:0] FMT_LE_FLT = 2'd3;

    typedef enum logic [2:0] {
        PH_MAGIC   = 3'b001,
        PH_HEADER  = 3'b010,
        PH_PAYLOAD = 3'b100
    } phase_t;

    typedef struct packed {
        logic        found;
        logic [1:0]  fmt;
        logic [23:0] len;
        logic [63:0] ts;
        logic [3:0]  flags;
    } hdr_dec_t;

    typedef struct packed {
        logic [1:0]  item_kind;
        logic [23:0] frame_length;
        logic [63:0] timestamp;
        logic [3:0]  frame_flags;
        logic [1:0]  header_format;
        logic [7:0]  payload_byte;
        logic        last_byte;
    } result_t;

endpackage

// ----- rtl/fhd_in_if.sv -----
interface fhd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       conn_start;

    modport source (output valid, output in_byte, output conn_start, input ready);
    modport sink (input valid, input in_byte, input conn_start, output ready);
endinterface

// ----- rtl/fhd_out_if.sv -----
interface fhd_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  item_kind;
    logic [23:0] frame_length;
    logic [63:0] timestamp;
    logic [3:0]  frame_flags;
    logic [1:0]  header_format;
    logic [7:0]  payload_byte;
    logic        last_byte;

    modport source (
        output valid, output item_kind, output frame_length, output timestamp,
        output frame_flags, output header_format, output payload_byte,
        output last_byte, input ready
    );
    modport sink (
        input valid, input item_kind, input frame_length, input timestamp,
        input frame_flags, input header_format, input payload_byte,
        input last_byte, output ready
    );
endinterface

// ----- rtl/fhd_cfg_if.sv -----
interface fhd_cfg_if;
    logic        valid;
    logic        ready;
    logic [23:0] data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/fhd_hdr_dec.sv -----
module fhd_hdr_dec (
    input  logic [127:0]      hdr,
    input  logic [23:0]       max_len,
    input  logic              locked,
    input  logic [1:0]        lock_fmt,
    output fhd_pkg::hdr_dec_t dec
);
    import fhd_pkg::*;

    function automatic logic [63:0] get_word(
        input logic [127:0] h,
        input int           off,
        input int           n,
        input logic         big
    );
        logic [63:0] v;
        logic [7:0]  b;
        v = '0;
        for (int i = 0; i < 8; i++)
        begin
            if (i < n)
            begin
                b = h[8 * ((off + i) & 15) +: 8];
                if (big)
                begin
                    v = {v[55:0], b};
                end
                else
                begin
                    v[8 * i +: 8] = b;
                end
            end
        end
        return v;
    endfunction

    logic [31:0] lens  [4];
    logic [31:0] flgs  [4];
    logic [63:0] tss   [4];
    logic [3:0]  pass;

    // four layouts side by side
    always_comb
    begin
        for (int g = 0; g < 4; g++)
        begin
            if (g < 2)
            begin
                lens[g] = 32'(get_word(hdr, 0, 4, (g & 1) == 0));
                tss[g]  = get_word(hdr, 4, 8, (g & 1) == 0);
                flgs[g] = 32'(get_word(hdr, 12, 4, (g & 1) == 0));
            end
            else
            begin
                flgs[g] = 32'(get_word(hdr, 0, 4, (g & 1) == 0));
                lens[g] = 32'(get_word(hdr, 4, 4, (g & 1) == 0));
                tss[g]  = get_word(hdr, 8, 8, (g & 1) == 0);
            end
            pass[g] = (lens[g][31:24] == 8'd0) && (lens[g][23:0] <= max_len)
                && ((flgs[g] & ~FLAGS_ALLOWED) == 32'd0)
                && !((lens[g] == 32'd0) && ((flgs[g] & (FLAG_END | FLAG_CFG)) == 32'd0));
        end
    end

    // locked layout only, otherwise first passing one
    always_comb
    begin
        dec.found = 1'b0;
        dec.fmt   = FMT_BE_LTF;
        if (locked)
        begin
            dec.found = pass[lock_fmt];
            dec.fmt   = lock_fmt;
        end
        else if (pass[0])
        begin
            dec.found = 1'b1;
            dec.fmt   = FMT_BE_LTF;
        end
        else if (pass[1])
        begin
            dec.found = 1'b1;
            dec.fmt   = FMT_LE_LTF;
        end
        else if (pass[2])
        begin
            dec.found = 1'b1;
            dec.fmt   = FMT_BE_FLT;
        end
        else if (pass[3])
        begin
            dec.found = 1'b1;
            dec.fmt   = FMT_LE_FLT;
        end
        dec.len   = lens[dec.fmt][23:0];
        dec.ts    = tss[dec.fmt];
        dec.flags = flgs[dec.fmt][3:0];
    end
endmodule

// ----- rtl/frame_header_deframer_top.sv -----
// channel  modport  payload
// stream   sink     in_byte, conn_start
// result   source   item_kind, frame_length, timestamp, frame_flags,
//                   header_format, payload_byte, last_byte
// cfg      sink     data (max_frame_length)
//
// one byte per cycle while result is not stalled; a result is registered
// the path is input register, header decode and framing logic, result register
// bytes that make no result still pass through the core slot
// reset clears framing, format lock and max_frame_length (8388608); header store has no reset
// a stalled result holds the core; the input register still takes one more beat
module frame_header_deframer_top (
    input logic     clk,
    input logic     rst_n,
    fhd_in_if.sink  stream,
    fhd_out_if.source result,
    fhd_cfg_if.sink cfg
);
    import fhd_pkg::*;
    `include "frame_header_deframer_top_defines.svh"

    logic [23:0]  max_len_reg;

    logic         in_vld_reg;
    logic [7:0]   in_byte_reg;
    logic         in_conn_reg;

    phase_t       phase_reg, phase_next;
    logic [31:0]  window_reg, window_next;
    logic [2:0]   fill_reg, fill_next;
    logic         slide_reg, slide_next;
    logic [3:0]   count_reg, count_next;
    logic         locked_reg, locked_next;
    logic [1:0]   lfmt_reg, lfmt_next;
    logic [23:0]  rem_reg, rem_next;
    logic [7:0]   hdr_mem [16];

    logic         out_vld_reg;
    result_t      out_reg;

    phase_t       eff_phase;
    logic [31:0]  eff_window;
    logic [2:0]   eff_fill;
    logic         eff_slide;
    logic [3:0]   eff_count;
    logic         eff_locked;
    logic [1:0]   eff_lfmt;
    logic [23:0]  eff_rem;

    logic         core_go;
    logic         produce;
    result_t      res;
    logic [127:0] hdr_vec;
    hdr_dec_t     dec;
    logic [31:0]  win_shift;
    logic [2:0]   fill_inc;
    logic [23:0]  rem_dec;

    assign core_go      = in_vld_reg && (!out_vld_reg || result.ready);
    assign stream.ready = !in_vld_reg || core_go;
    assign cfg.ready    = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg <= LEN_RESET;
        end
        else if (cfg.valid)
        begin
            max_len_reg <= cfg.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (stream.ready)
        begin
            in_vld_reg <= stream.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stream.ready && stream.valid)
        begin
            in_byte_reg <= stream.in_byte;
            in_conn_reg <= stream.conn_start;
        end
    end

    // new connection clears lock and framing first
    always_comb
    begin
        if (in_conn_reg)
        begin
            eff_phase  = PH_MAGIC;
            eff_window = '0;
            eff_fill   = '0;
            eff_slide  = 1'b0;
            eff_count  = '0;
            eff_locked = 1'b0;
            eff_lfmt   = FMT_BE_LTF;
            eff_rem    = '0;
        end
        else
        begin
            eff_phase  = phase_reg;
            eff_window = window_reg;
            eff_fill   = fill_reg;
            eff_slide  = slide_reg;
            eff_count  = count_reg;
            eff_locked = locked_reg;
            eff_lfmt   = lfmt_reg;
            eff_rem    = rem_reg;
        end
    end

    always_comb
    begin
        for (int i = 0; i < 15; i++)
        begin
            hdr_vec[8 * i +: 8] = hdr_mem[i];
        end
        hdr_vec[127:120] = in_byte_reg;
    end

    fhd_hdr_dec u_hdr_dec (
        .hdr      (hdr_vec),
        .max_len  (max_len_reg),
        .locked   (eff_locked),
        .lock_fmt (eff_lfmt),
        .dec      (dec)
    );

    assign win_shift = {eff_window[23:0], in_byte_reg};
    assign fill_inc  = (eff_fill < 3'd4) ? eff_fill + 3'd1 : eff_fill;
    assign rem_dec   = (eff_rem != 24'd0) ? eff_rem - 24'd1 : eff_rem;

    always_comb
    begin
        phase_next  = eff_phase;
        window_next = eff_window;
        fill_next   = eff_fill;
        slide_next  = eff_slide;
        count_next  = eff_count;
        locked_next = eff_locked;
        lfmt_next   = eff_lfmt;
        rem_next    = eff_rem;
        produce     = 1'b0;
        res         = '0;
        case (eff_phase)
            PH_HEADER:
            begin
                if (eff_count != 4'd15)
                begin
                    count_next = eff_count + 4'd1;
                end
                else
                begin
                    count_next = '0;
                    produce    = 1'b1;
                    if (dec.found)
                    begin
                        locked_next       = 1'b1;
                        lfmt_next         = dec.fmt;
                        res.item_kind     = KIND_HEADER;
                        res.frame_length  = dec.len;
                        res.timestamp     = dec.ts;
                        res.frame_flags   = dec.flags;
                        res.header_format = dec.fmt;
                        rem_next          = dec.len;
                        phase_next        = (dec.len != 24'd0) ? PH_PAYLOAD : PH_MAGIC;
                    end
                    else
                    begin
                        res.item_kind = KIND_DROP;
                        phase_next    = PH_MAGIC;
                        slide_next    = 1'b1;
                        window_next   = '0;
                        fill_next     = '0;
                    end
                end
            end
            PH_PAYLOAD:
            begin
                produce          = 1'b1;
                res.item_kind    = KIND_PAYLOAD;
                res.payload_byte = in_byte_reg;
                res.last_byte    = (eff_rem <= 24'd1);
                rem_next         = rem_dec;
                if (rem_dec == 24'd0)
                begin
                    phase_next = PH_MAGIC;
                end
            end
            default:
            begin
                phase_next  = PH_MAGIC;
                window_next = win_shift;
                fill_next   = fill_inc;
                if (fill_inc >= 3'd4)
                begin
                    if (win_shift == MAGIC_WORD)
                    begin
                        phase_next  = PH_HEADER;
                        count_next  = '0;
                        slide_next  = 1'b0;
                        window_next = '0;
                        fill_next   = '0;
                    end
                    else if (!eff_slide)
                    begin
                        slide_next  = 1'b1;
                        window_next = '0;
                        fill_next   = '0;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_MAGIC;
            window_reg <= '0;
            fill_reg   <= '0;
            slide_reg  <= 1'b0;
            count_reg  <= '0;
            locked_reg <= 1'b0;
            lfmt_reg   <= FMT_BE_LTF;
            rem_reg    <= '0;
        end
        else if (core_go)
        begin
            phase_reg  <= phase_next;
            window_reg <= window_next;
            fill_reg   <= fill_next;
            slide_reg  <= slide_next;
            count_reg  <= count_next;
            locked_reg <= locked_next;
            lfmt_reg   <= lfmt_next;
            rem_reg    <= rem_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (core_go && (eff_phase == PH_HEADER))
        begin
            hdr_mem[eff_count] <= in_byte_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (!out_vld_reg || result.ready)
        begin
            out_vld_reg <= core_go && produce;
        end
    end

    always_ff @(posedge clk)
    begin
        if (core_go && produce)
        begin
            out_reg <= res;
        end
    end

    assign result.valid         = out_vld_reg;
    assign result.item_kind     = out_reg.item_kind;
    assign result.frame_length  = out_reg.frame_length;
    assign result.timestamp     = out_reg.timestamp;
    assign result.frame_flags   = out_reg.frame_flags;
    assign result.header_format = out_reg.header_format;
    assign result.payload_byte  = out_reg.payload_byte;
    assign result.last_byte     = out_reg.last_byte;

    `FHD_ASSERT(a_phase_onehot, $onehot(phase_reg), "phase register not one-hot")
    `FHD_ASSERT(a_fill_range, fill_reg <= 3'd4, "magic window fill out of range")
    `FHD_ASSERT(a_last_ends_frame,
        core_go && produce && (res.item_kind == KIND_PAYLOAD) && res.last_byte
            |=> phase_reg == PH_MAGIC,
        "last payload beat did not return to magic search")
    `FHD_ASSERT(a_drop_clean,
        result.valid && (result.item_kind == KIND_DROP)
            |-> (result.frame_length == 24'd0) && (result.timestamp == 64'd0)
                && (result.header_format == FMT_BE_LTF),
        "drop result carries header fields")
endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps

module tb;
    import fhd_pkg::*;

    localparam int STALL_LIMIT = 1000;
    localparam int SETTLE_CYCLES = 8;

    logic clk;
    logic rst_n;

    fhd_in_if stream_bus ();
    fhd_out_if result_bus ();
    fhd_cfg_if cfg_bus ();

    frame_header_deframer_top uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .stream (stream_bus),
        .result (result_bus),
        .cfg    (cfg_bus)
    );

    // deframer state as seen from outside
    logic [23:0] max_len;
    phase_t      scan_phase;
    logic [31:0] magic_win;
    logic [2:0]  win_fill;
    bit          sliding;
    logic [7:0]  hdr_seen [16];
    logic [3:0]  hdr_count;
    bit          conn_locked;
    logic [1:0]  conn_fmt;
    logic [23:0] remaining;

    result_t     due_items [$];
    logic [7:0]  hdr_tx [16];
    logic [1:0]  tx_fmt = FMT_BE_LTF;
    bit          no_idle = 1'b0;
    int          errors = 0;
    int          bytes_sent = 0;
    int          stall_cycles = 0;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic void clear_framing();
        scan_phase = PH_MAGIC;
        magic_win = '0;
        win_fill = '0;
        sliding = 1'b0;
        hdr_count = '0;
        remaining = '0;
    endfunction

    function automatic logic [63:0] hdr_word(input int off, input int n, input bit big);
        logic [63:0] v;
        v = '0;
        for (int i = 0; i < n; i++)
        begin
            if (big)
                v = {v[55:0], hdr_seen[off + i]};
            else
                v = v | (64'(hdr_seen[off + i]) << (8 * i));
        end
        return v;
    endfunction

    function automatic bit try_fmt(input logic [1:0] fmt, output logic [31:0] len,
                                   output logic [63:0] ts, output logic [31:0] flags);
        bit big;
        big = !fmt[0];
        if (!fmt[1])
        begin
            len = 32'(hdr_word(0, 4, big));
            ts = hdr_word(4, 8, big);
            flags = 32'(hdr_word(12, 4, big));
        end
        else
        begin
            flags = 32'(hdr_word(0, 4, big));
            len = 32'(hdr_word(4, 4, big));
            ts = hdr_word(8, 8, big);
        end
        if (len > 32'(max_len))
            return 1'b0;
        if ((flags & ~FLAGS_ALLOWED) != 0)
            return 1'b0;
        if (len == 0 && (flags & (FLAG_END | FLAG_CFG)) == 0)
            return 1'b0;
        return 1'b1;
    endfunction

    function automatic void deframe_byte(input logic [7:0] b, input bit cs);
        result_t     r;
        logic [31:0] len;
        logic [63:0] ts;
        logic [31:0] flags;
        logic [2:0]  found;
        r = '0;
        found = 3'd4;
        if (cs)
        begin
            conn_locked = 1'b0;
            conn_fmt = '0;
            clear_framing();
        end
        case (scan_phase)
            PH_HEADER:
            begin
                hdr_seen[hdr_count] = b;
                if (hdr_count < 15)
                begin
                    hdr_count++;
                    return;
                end
                hdr_count = '0;
                if (conn_locked)
                begin
                    if (try_fmt(conn_fmt, len, ts, flags))
                        found = {1'b0, conn_fmt};
                end
                else
                begin
                    for (int f = 0; f < 4 && found == 3'd4; f++)
                    begin
                        if (try_fmt(2'(f), len, ts, flags))
                            found = 3'(f);
                    end
                end
                if (found != 3'd4)
                begin
                    conn_locked = 1'b1;
                    conn_fmt = found[1:0];
                    r.item_kind = KIND_HEADER;
                    r.frame_length = len[23:0];
                    r.timestamp = ts;
                    r.frame_flags = flags[3:0];
                    r.header_format = found[1:0];
                    remaining = len[23:0];
                    scan_phase = (remaining != 0) ? PH_PAYLOAD : PH_MAGIC;
                end
                else
                begin
                    r.item_kind = KIND_DROP;
                    scan_phase = PH_MAGIC;
                    sliding = 1'b1;
                    magic_win = '0;
                    win_fill = '0;
                end
                due_items.push_back(r);
            end
            PH_PAYLOAD:
            begin
                r.item_kind = KIND_PAYLOAD;
                r.payload_byte = b;
                r.last_byte = (remaining <= 1);
                if (remaining != 0)
                    remaining--;
                if (remaining == 0)
                    scan_phase = PH_MAGIC;
                due_items.push_back(r);
            end
            default:
            begin
                scan_phase = PH_MAGIC;
                magic_win = {magic_win[23:0], b};
                if (win_fill < 4)
                    win_fill++;
                if (win_fill >= 4)
                begin
                    if (magic_win == MAGIC_WORD)
                    begin
                        scan_phase = PH_HEADER;
                        hdr_count = '0;
                        sliding = 1'b0;
                        magic_win = '0;
                        win_fill = '0;
                    end
                    else if (!sliding)
                    begin
                        sliding = 1'b1;
                        magic_win = '0;
                        win_fill = '0;
                    end
                end
            end
        endcase
    endfunction

    task automatic send_byte(input logic [7:0] b, input bit cs);
        while (!no_idle && $urandom_range(0, 99) < 20)
        begin
            @(negedge clk);
            stream_bus.valid <= 1'b0;
        end
        @(negedge clk);
        stream_bus.valid <= 1'b1;
        stream_bus.in_byte <= b;
        stream_bus.conn_start <= cs;
        do
            @(posedge clk);
        while (!stream_bus.ready);
        deframe_byte(b, cs);
        bytes_sent++;
    endtask

    function automatic void put_field(input int off, input int n, input logic [63:0] v,
                                      input bit big);
        for (int i = 0; i < n; i++)
            hdr_tx[off + i] = big ? v[8 * (n - 1 - i) +: 8] : v[8 * i +: 8];
    endfunction

    task automatic send_frame(input logic [1:0] fmt, input logic [31:0] len,
                              input logic [63:0] ts, input logic [31:0] flags,
                              input bit cs, input int hdr_n, input int pay_n);
        bit big;
        big = !fmt[0];
        if (!fmt[1])
        begin
            put_field(0, 4, 64'(len), big);
            put_field(4, 8, ts, big);
            put_field(12, 4, 64'(flags), big);
        end
        else
        begin
            put_field(0, 4, 64'(flags), big);
            put_field(4, 4, 64'(len), big);
            put_field(8, 8, ts, big);
        end
        for (int i = 0; i < 4; i++)
            send_byte(MAGIC_WORD[31 - 8 * i -: 8], cs && i == 0);
        for (int i = 0; i < hdr_n; i++)
            send_byte(hdr_tx[i], 1'b0);
        for (int i = 0; i < pay_n; i++)
            send_byte(8'($urandom_range(0, 255)), 1'b0);
    endtask

    // wait for all results, then let bytes that make none clear the pipeline
    task automatic settle();
        @(negedge clk);
        stream_bus.valid <= 1'b0;
        while (due_items.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_max_length(input logic [23:0] v);
        settle();
        @(negedge clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.data <= v;
        do
            @(posedge clk);
        while (!cfg_bus.ready);
        max_len = v;
        @(negedge clk);
        cfg_bus.valid <= 1'b0;
    endtask

    function automatic void check_field(input string name, input logic [63:0] exp_v,
                                        input logic [63:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s: expected %0h, got %0h", name, exp_v, act_v);
            errors++;
        end
    endfunction

    initial
    begin
        result_t exp_r;
        result_bus.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (result_bus.valid && result_bus.ready)
            begin
                if (due_items.size() == 0)
                begin
                    $error("result beat with nothing expected");
                    errors++;
                end
                else
                begin
                    exp_r = due_items.pop_front();
                    check_field("item_kind", 64'(exp_r.item_kind),
                                64'(result_bus.item_kind));
                    check_field("frame_length", 64'(exp_r.frame_length),
                                64'(result_bus.frame_length));
                    check_field("timestamp", exp_r.timestamp, result_bus.timestamp);
                    check_field("frame_flags", 64'(exp_r.frame_flags),
                                64'(result_bus.frame_flags));
                    check_field("header_format", 64'(exp_r.header_format),
                                64'(result_bus.header_format));
                    check_field("payload_byte", 64'(exp_r.payload_byte),
                                64'(result_bus.payload_byte));
                    check_field("last_byte", 64'(exp_r.last_byte),
                                64'(result_bus.last_byte));
                end
            end
            @(negedge clk);
            result_bus.ready <= no_idle || ($urandom_range(0, 99) >= 20);
        end
    end

    always @(posedge clk)
    begin
        if ((stream_bus.valid && stream_bus.ready) || (result_bus.valid && result_bus.ready)
            || (cfg_bus.valid && cfg_bus.ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic test_reset_limit();
        send_frame(FMT_BE_LTF, 32'(LEN_RESET) + 1, 64'h0123_4567_89AB_CDEF, FLAG_KEY,
                   1'b1, 16, 0);
    endtask

    task automatic test_each_format();
        for (int f = 0; f < 4; f++)
            send_frame(2'(f), 32'd2, 64'hC0FFEE42_DEADBEEF, FLAG_KEY, 1'b1, 16, 2);
        tx_fmt = FMT_LE_FLT;
    endtask

    task automatic test_zero_length();
        send_frame(tx_fmt, 32'd0, 64'd0, FLAG_END, 1'b0, 16, 0);
        send_frame(tx_fmt, 32'd0, '1, FLAG_CFG | FLAG_KEY, 1'b0, 16, 0);
        send_frame(tx_fmt, 32'd0, 64'd5, FLAG_KEY, 1'b0, 16, 0);
        send_frame(tx_fmt, 32'd1, {$urandom, $urandom}, FLAG_KEY, 1'b0, 16, 1);
    endtask

    task automatic test_resync();
        // junk ahead of the magic breaks the aligned check
        send_byte("x", 1'b0);
        send_byte("y", 1'b0);
        send_byte("z", 1'b0);
        send_frame(tx_fmt, 32'd1, 64'd7, FLAG_KEY, 1'b0, 16, 1);
        send_frame(tx_fmt, 32'd2, 64'd8, FLAG_END, 1'b0, 16, 2);
        send_frame(tx_fmt, 32'd1, 64'd9, 32'h0000_0002, 1'b0, 16, 0);
        send_byte("F", 1'b0);
        send_byte("R", 1'b0);
        send_frame(tx_fmt, 32'd1, 64'd10, FLAG_CFG, 1'b0, 16, 1);
    endtask

    // run back to back on both sides
    task automatic test_length_limits();
        no_idle = 1'b1;
        set_max_length(24'd0);
        send_frame(tx_fmt, 32'd0, 64'd1, FLAG_END, 1'b0, 16, 0);
        send_frame(tx_fmt, 32'd1, 64'd2, FLAG_KEY, 1'b0, 16, 0);
        set_max_length(24'd3);
        send_frame(tx_fmt, 32'd3, 64'd3, FLAG_KEY, 1'b0, 16, 3);
        send_frame(tx_fmt, 32'd4, 64'd4, FLAG_KEY, 1'b0, 16, 0);
        set_max_length(24'hFF_FFFF);
        send_frame(tx_fmt, 32'h0100_0000, 64'd5, FLAG_KEY, 1'b0, 16, 0);
        send_frame(tx_fmt, 32'd6, 64'd6, 32'h0000_000D, 1'b0, 16, 6);
        no_idle = 1'b0;
    endtask

    task automatic test_new_connection();
        send_frame(FMT_BE_LTF, 32'd4, 64'd11, FLAG_KEY, 1'b1, 16, 2);
        send_frame(FMT_LE_LTF, 32'd3, 64'd12, FLAG_KEY, 1'b1, 7, 0);
        send_frame(FMT_BE_FLT, 32'd1, 64'd13, FLAG_KEY, 1'b1, 16, 1);
        tx_fmt = FMT_BE_FLT;
    endtask

    task automatic random_frames(input int n);
        int          stop_at;
        int          cap;
        int          pay;
        int          hdr_n;
        int          pos;
        logic [31:0] len;
        logic [31:0] flags;
        logic [63:0] ts;
        logic [1:0]  fmt;
        bit          cs;
        stop_at = bytes_sent + n;
        while (bytes_sent < stop_at)
        begin
            if ($urandom_range(0, 99) < 10)
            begin
                repeat ($urandom_range(1, 6))
                    send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
            end
            else
            begin
                cs = ($urandom_range(0, 7) == 0);
                if (cs)
                    tx_fmt = 2'($urandom_range(0, 3));
                fmt = ($urandom_range(0, 9) == 0) ? 2'($urandom_range(0, 3)) : tx_fmt;
                cap = (max_len < 6) ? int'(max_len) : 6;
                len = 32'($urandom_range(0, cap));
                if (max_len <= 16 && $urandom_range(0, 5) == 0)
                    len = 32'(max_len);
                flags = {28'd0, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b0,
                         1'($urandom_range(0, 1))};
                if (len == 0 && (flags & (FLAG_END | FLAG_CFG)) == 0)
                    flags = flags | ($urandom_range(0, 1) ? FLAG_END : FLAG_CFG);
                case ($urandom_range(0, 3))
                    0: ts = '0;
                    1: ts = '1;
                    default: ts = {$urandom, $urandom};
                endcase
                pay = int'(len);
                hdr_n = 16;
                case ($urandom_range(0, 19))
                    0:
                    begin
                        pos = $urandom_range(0, 28);
                        flags = flags | (32'd1 << ((pos == 0) ? 1 : pos + 3));
                        pay = $urandom_range(0, 3);
                    end
                    1:
                    begin
                        len = 32'(max_len) + 1;
                        pay = $urandom_range(0, 3);
                    end
                    2:
                    begin
                        len = 32'd0;
                        flags = flags & FLAG_KEY;
                        pay = $urandom_range(0, 3);
                    end
                    3: hdr_n = $urandom_range(0, 15);
                    default: ;
                endcase
                send_frame(fmt, len, ts, flags, cs, hdr_n, pay);
            end
        end
    endtask

    task automatic test_random_traffic();
        random_frames(15);
        set_max_length(24'($urandom_range(1, 12)));
        random_frames(10);
        set_max_length(24'($urandom_range(0, 2)));
        random_frames(10);
    endtask

    initial
    begin
        rst_n = 1'b0;
        stream_bus.valid = 1'b0;
        stream_bus.in_byte = '0;
        stream_bus.conn_start = 1'b0;
        cfg_bus.valid = 1'b0;
        cfg_bus.data = '0;
        max_len = LEN_RESET;
        conn_locked = 1'b0;
        conn_fmt = '0;
        clear_framing();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_limit();
        test_each_format();
        test_zero_length();
        test_resync();
        test_length_limits();
        test_new_connection();
        test_random_traffic();

        settle();
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
